>>> hdl/rsd_pkg.sv
`default_nettype none
package rsd_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 15;

   localparam int CFG_W    = 15;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_W    = 16;

   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_RADIUS = 2'd1;

   localparam logic [CFG_W-1:0] FULL_SCALE_RST  = 15'd32767;
   localparam logic [CFG_W-1:0] DEAD_RADIUS_RST = 15'd7849;

   localparam logic [OUT_W:0] POS_LIMIT = 17'd32767;
   localparam logic [OUT_W:0] NEG_LIMIT = 17'd32768;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic dead;
      logic zero;
   } flags_type;

endpackage
`default_nettype wire

>>> hdl/rsd_sqrt.sv
`default_nettype none
// pipelined integer square root, one root bit per stage
module rsd_sqrt #(
   parameter int S = rsd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [2*S-1:0] n,
   output logic      [S-1:0]   root
);
   localparam int RW = S + 2;

   logic [RW-1:0]  rem_ff  [S];
   logic [S-1:0]   root_ff [S];
   logic [2*S-1:0] n_ff    [S];

   for (genvar k = 0; k < S; k++) begin : g_stage
      logic [RW-1:0]  rem_p;
      logic [S-1:0]   root_p;
      logic [2*S-1:0] n_p;
      logic [RW+1:0]  shifted;
      logic [RW+1:0]  trial;
      logic           ge;
      logic [RW-1:0]  rem_in;
      logic [S-1:0]   root_in;
      logic [2*S-1:0] n_in;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign n_p    = n;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign n_p    = n_ff[k-1];
      end

      always_comb begin
         shifted = {rem_p, n_p[2*S-1:2*S-2]};
         trial   = (RW+2)'({root_p, 2'b01});
         ge      = shifted >= trial;
         rem_in  = ge ? RW'(shifted - trial) : RW'(shifted);
         root_in = {root_p[S-2:0], ge};
         n_in    = {n_p[2*S-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            n_ff[k]    <= n_in;
         end
      end
   end

   assign root = root_ff[S-1];
endmodule
`default_nettype wire

>>> hdl/rsd_div.sv
`default_nettype none
// pipelined restoring divider for a <= d, quotient (a << (Q-1)) / d
module rsd_div #(
   parameter int W = 31,
   parameter int Q = 16
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] d,
   output logic      [Q-1:0] q
);
   logic [W-1:0] rem_ff [Q];
   logic [W-1:0] d_ff   [Q];
   logic [Q-1:0] q_ff   [Q];

   for (genvar k = 0; k < Q; k++) begin : g_stage
      logic [W:0]   t;
      logic [W-1:0] d_p;
      logic [Q-1:0] q_p;
      logic         ge;
      logic [W-1:0] rem_in;
      logic [Q-1:0] q_in;

      if (k == 0) begin : g_first
         assign t   = {1'b0, a};
         assign d_p = d;
         assign q_p = '0;
      end else begin : g_next
         assign t   = {rem_ff[k-1], 1'b0};
         assign d_p = d_ff[k-1];
         assign q_p = q_ff[k-1];
      end

      always_comb begin
         ge     = t >= {1'b0, d_p};
         rem_in = ge ? W'(t - {1'b0, d_p}) : W'(t);
         q_in   = {q_p[Q-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            d_ff[k]   <= d_p;
            q_ff[k]   <= q_in;
         end
      end
   end

   assign q = q_ff[Q-1];
endmodule
`default_nettype wire

>>> hdl/radial_stick_deadzone.sv
// channel  | direction | ports
// req      | in        | req_valid, req_stall, req_x_in, req_y_in
// rsp      | out       | rsp_valid, rsp_stall, rsp_x_out, rsp_y_out, rsp_in_dead_zone
// csr      | in        | csr_write_en, csr_index, csr_wdata
//
// one sample enters per cycle while a held result on rsp does not stall the pipeline
// most pipeline stages come from the square root (one stage per root bit) and the two dividers
// (one stage per quotient bit), all fully pipelined
// synchronous reset clears valid bits and loads the register reset values
// a held result on rsp freezes the whole pipeline and raises req_stall
`default_nettype none
module radial_stick_deadzone #(
   parameter int SAMPLE_BITS = rsd_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = rsd_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [15:0]              req_x_in,
   input  wire logic signed [15:0]              req_y_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [rsd_pkg::OUT_W-1:0]     rsp_x_out,
   output logic signed [rsd_pkg::OUT_W-1:0]     rsp_y_out,
   output logic                                 rsp_in_dead_zone,
   input  wire logic                            csr_write_en,
   input  wire logic [rsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rsd_pkg::CFG_W-1:0]       csr_wdata
);
   localparam int S  = SAMPLE_BITS;
   localparam int W  = S + rsd_pkg::CFG_W;  // products and divisor width
   localparam int Q  = FRAC_BITS + 1;       // quotient reaches 2^FRAC_BITS
   localparam int SL = S + 1;               // stage b plus root stages
   localparam int OW = rsd_pkg::OUT_W;

   // config registers
   logic [rsd_pkg::CFG_W-1:0] fs_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= rsd_pkg::FULL_SCALE_RST;
         dz_ff <= rsd_pkg::DEAD_RADIUS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            rsd_pkg::REG_FULL_SCALE:  fs_ff <= csr_wdata;
            rsd_pkg::REG_DEAD_RADIUS: dz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipe moves unless the output holds a result that is not taken
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage a: take the low SAMPLE_BITS bits as signed, keep signs and take magnitudes
   logic signed [S-1:0] xs, ys;
   logic [S-1:0]        ax_in, ay_in;
   logic [S-1:0]        ax_ff, ay_ff;
   rsd_pkg::flags_type  fa_in, fa_ff;

   always_comb begin
      xs       = req_x_in[S-1:0];
      ys       = req_y_in[S-1:0];
      ax_in    = xs[S-1] ? S'(-xs) : S'(xs);
      ay_in    = ys[S-1] ? S'(-ys) : S'(ys);
      fa_in    = '0;
      fa_in.x_neg = xs[S-1];
      fa_in.y_neg = ys[S-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         fa_ff <= fa_in;
      end
   end

   // stage b: sum of squares
   logic [2*S-1:0] sum_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= (2*S)'(ax_ff) * (2*S)'(ax_ff) + (2*S)'(ay_ff) * (2*S)'(ay_ff);
      end
   end

   // side data riding along stage b and the root stages
   logic [S-1:0]       axd_ff [SL];
   logic [S-1:0]       ayd_ff [SL];
   rsd_pkg::flags_type fd_ff  [SL];

   always_ff @(posedge clock) begin
      if (en) begin
         axd_ff[0] <= ax_ff;
         ayd_ff[0] <= ay_ff;
         fd_ff[0]  <= fa_ff;
         for (int i = 1; i < SL; i++) begin
            axd_ff[i] <= axd_ff[i-1];
            ayd_ff[i] <= ayd_ff[i-1];
            fd_ff[i]  <= fd_ff[i-1];
         end
      end
   end

   logic [S-1:0] root;
   rsd_sqrt #(.S(S)) u_sqrt (
      .clock (clock),
      .en    (en),
      .n     (sum_ff),
      .root  (root)
   );

   // stage c: dead zone test, numerator and divisor products
   logic [W-1:0]       r_w, fs_w, dz_w, rc_w;
   logic [rsd_pkg::CFG_W-1:0] num, span;
   rsd_pkg::flags_type fc_in, fc_ff;
   logic [W-1:0]       ax_num_ff, ay_num_ff, den_ff;

   always_comb begin
      r_w   = W'(root);
      fs_w  = W'(fs_ff);
      dz_w  = W'(dz_ff);
      rc_w  = (r_w > fs_w) ? fs_w : r_w;
      num   = rsd_pkg::CFG_W'(rc_w - dz_w);
      span  = fs_ff - dz_ff;
      fc_in = fd_ff[SL-1];
      fc_in.dead = r_w <= dz_w;
      fc_in.zero = (r_w <= dz_w) || (dz_ff >= fs_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_num_ff <= W'(axd_ff[SL-1]) * W'(num);
         ay_num_ff <= W'(ayd_ff[SL-1]) * W'(num);
         den_ff    <= r_w * W'(span);
         fc_ff     <= fc_in;
      end
   end

   // per-axis quotient: |axis| * num * 2^FRAC_BITS / (r * span)
   logic [Q-1:0] qx, qy;
   rsd_div #(.W(W), .Q(Q)) u_div_x (
      .clock (clock), .en (en), .a (ax_num_ff), .d (den_ff), .q (qx)
   );
   rsd_div #(.W(W), .Q(Q)) u_div_y (
      .clock (clock), .en (en), .a (ay_num_ff), .d (den_ff), .q (qy)
   );

   rsd_pkg::flags_type fq_ff [Q];
   always_ff @(posedge clock) begin
      if (en) begin
         fq_ff[0] <= fc_ff;
         for (int i = 1; i < Q; i++) begin
            fq_ff[i] <= fq_ff[i-1];
         end
      end
   end

   // valid bits for every stage up to the output register
   localparam int VL = 1 + SL + 1 + Q;
   logic [VL-1:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[VL-2:0], req_valid};
      end
   end

   // output stage: apply sign, saturate, zero in the dead zone or when dead radius >= full scale
   function automatic logic [OW-1:0] apply_sign(input logic [Q-1:0] q, input logic neg);
      logic [OW:0] qe;
      logic [OW:0] m;
      qe = (OW+1)'(q);
      if (neg) begin
         m = (qe > rsd_pkg::NEG_LIMIT) ? rsd_pkg::NEG_LIMIT : qe;
         return OW'((OW+1)'(0) - m);
      end
      return (qe > rsd_pkg::POS_LIMIT) ? OW'(rsd_pkg::POS_LIMIT) : OW'(qe);
   endfunction

   rsd_pkg::flags_type fo;
   logic [OW-1:0]      xo_in, yo_in;
   logic               out_valid_ff;
   logic [OW-1:0]      xo_ff, yo_ff;
   logic               dz_flag_ff;

   always_comb begin
      fo    = fq_ff[Q-1];
      xo_in = fo.zero ? '0 : apply_sign(qx, fo.x_neg);
      yo_in = fo.zero ? '0 : apply_sign(qy, fo.y_neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ff[VL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xo_ff      <= xo_in;
         yo_ff      <= yo_in;
         dz_flag_ff <= fo.dead;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_x_out        = xo_ff;
   assign rsp_y_out        = yo_ff;
   assign rsp_in_dead_zone = dz_flag_ff;
endmodule
`default_nettype wire

>>> hdl/rsd_checker.sv
`default_nettype none
module rsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_x_out,
   input wire logic [15:0] rsp_y_out,
   input wire logic        rsp_in_dead_zone
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_out) && $stable(rsp_y_out))
      else $error("held result changed");

   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_dead_zone |-> rsp_x_out == 16'd0 && rsp_y_out == 16'd0)
      else $error("dead zone result not zero");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");
endmodule

bind radial_stick_deadzone rsd_checker u_rsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_x_out        (rsp_x_out),
   .rsp_y_out        (rsp_y_out),
   .rsp_in_dead_zone (rsp_in_dead_zone)
);
`default_nettype wire

>>> verif/radial_stick_deadzone_tb.sv
`default_nettype none
module radial_stick_deadzone_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // settle beyond the pipeline latency after the last expected result
   localparam int SETTLE_CYCLES = 48;
   localparam int CYCLE_LIMIT   = 600000;

   typedef struct {
      logic signed [rsd_pkg::OUT_W-1:0] x_out;
      logic signed [rsd_pkg::OUT_W-1:0] y_out;
      logic                             in_dead_zone;
   } stick_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [15:0]                 req_x_in = '0;
   logic signed [15:0]                 req_y_in = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [rsd_pkg::OUT_W-1:0]   rsp_x_out;
   logic signed [rsd_pkg::OUT_W-1:0]   rsp_y_out;
   logic                               rsp_in_dead_zone;
   logic                               csr_write_en = 1'b0;
   logic [rsd_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [rsd_pkg::CFG_W-1:0]          csr_wdata = '0;

   // shadow copy of the two registers
   logic [rsd_pkg::CFG_W-1:0]          full_scale_q;
   logic [rsd_pkg::CFG_W-1:0]          dead_radius_q;

   stick_result_type                   pending_results[$];
   int                                 fail_count = 0;
   int                                 cycle_count = 0;
   int                                 burst_left = 0;
   int                                 stall_pct = 0;

   radial_stick_deadzone DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_in         (req_x_in),
      .req_y_in         (req_y_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_x_out        (rsp_x_out),
      .rsp_y_out        (rsp_y_out),
      .rsp_in_dead_zone (rsp_in_dead_zone),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // floor of the square root, one result bit per pass
   function automatic longint root_floor(longint n);
      longint res;
      longint bitv;
      res  = 0;
      bitv = longint'(1) << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // axis * num / den in Q1.15, truncated toward zero and clamped
   function automatic logic signed [rsd_pkg::OUT_W-1:0] scale_axis(longint a, longint num,
                                                                  longint den);
      longint mag;
      longint q;
      mag = (a < 0) ? -a : a;
      q   = (mag * num * (longint'(1) << 15)) / den;
      if (a < 0) begin
         if (q > 32768) q = 32768;
         return rsd_pkg::OUT_W'(-q);
      end
      if (q > 32767) q = 32767;
      return rsd_pkg::OUT_W'(q);
   endfunction

   function automatic stick_result_type condition_sample(logic signed [15:0] xs,
                                                         logic signed [15:0] ys);
      stick_result_type res;
      longint        xv;
      longint        yv;
      longint        r;
      longint        fs;
      longint        dz;
      longint        rc;
      xv = longint'(xs);
      yv = longint'(ys);
      r  = root_floor(xv * xv + yv * yv);
      fs = longint'(full_scale_q);
      dz = longint'(dead_radius_q);
      res.x_out        = '0;
      res.y_out        = '0;
      res.in_dead_zone = (r <= dz);
      // dead radius at or above full scale forces zero output
      if (r > dz && dz < fs) begin
         rc = (r > fs) ? fs : r;
         res.x_out = scale_axis(xv, rc - dz, r * (fs - dz));
         res.y_out = scale_axis(yv, rc - dz, r * (fs - dz));
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   always @(posedge clock) begin
      stick_result_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_x_out !== want.x_out)
               report_mismatch("x_out", rsp_x_out, want.x_out);
            if (rsp_y_out !== want.y_out)
               report_mismatch("y_out", rsp_y_out, want.y_out);
            if (rsp_in_dead_zone !== want.in_dead_zone)
               report_mismatch("in_dead_zone", rsp_in_dead_zone, want.in_dead_zone);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: stall density is drawn anew at random, sometimes none at all
   always @(negedge clock) begin
      if (cycle_count % 64 == 0) begin
         case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // ---------------------------------------------------------------- drivers

   // one input transfer; valid stays high afterwards so bursts run back to back
   task automatic send_sample(logic signed [15:0] xs, logic signed [15:0] ys);
      @(negedge clock);
      req_valid <= 1'b1;
      req_x_in  <= xs;
      req_y_in  <= ys;
      do @(posedge clock); while (req_stall);
      pending_results = {pending_results, condition_sample(xs, ys)};
   endtask

   task automatic idle_cycles(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // bursts of random length separated by random gaps
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(0, 7));
      end
   endtask

   // stop sending until every expected result is out and the pipe is empty
   task automatic drain_results();
      idle_cycles(0);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [rsd_pkg::CSR_IDX_W-1:0] idx,
                            logic [rsd_pkg::CFG_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == rsd_pkg::REG_FULL_SCALE)       full_scale_q  = data;
      else if (idx == rsd_pkg::REG_DEAD_RADIUS) dead_radius_q = data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(logic [rsd_pkg::CFG_W-1:0] fs, logic [rsd_pkg::CFG_W-1:0] dz);
      drain_results();
      write_reg(rsd_pkg::REG_FULL_SCALE, fs);
      write_reg(rsd_pkg::REG_DEAD_RADIUS, dz);
   endtask

   function automatic logic signed [15:0] pick_axis();
      int sel;
      int mag;
      sel = $urandom_range(0, 9);
      if (sel < 4) return 16'($urandom);
      if (sel < 8) begin
         // magnitudes around the dead radius and the full scale
         mag = $urandom_range(0, 2 * int'(full_scale_q) + 2);
         if (mag > 32767) mag = 32767;
         return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      end
      case ($urandom_range(0, 3))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sh0000;
         default: return 16'shffff;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      // reset register values with corner samples, including zero length
      send_sample(16'sh0000, 16'sh0000);
      send_sample(16'sh7fff, 16'sh0000);
      send_sample(16'sh8000, 16'sh0000);
      send_sample(16'sh0000, 16'sh8000);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(16'sh8000, 16'sh7fff);
      send_sample(16'sd7849, 16'sd0);
      send_sample(16'sd7850, 16'sd0);
      send_sample(-16'sd5551, 16'sd5551);
      send_sample(16'sd20000, -16'sd12);
      send_sample(16'sh0001, 16'shffff);
   endtask

   task automatic test_config_edges();
      // dead radius above full scale: outputs zero, flag still reported
      set_config(15'd100, 15'd32767);
      send_sample(16'sd50, 16'sd0);
      send_sample(16'sh7fff, 16'sh8000);
      // dead radius equal to full scale
      set_config(15'd500, 15'd500);
      send_sample(16'sd501, 16'sd0);
      // full scale of zero
      set_config(15'd0, 15'd0);
      send_sample(16'sd3, -16'sd4);
      send_sample(16'sd0, 16'sd0);
      // narrowest live band: any nonzero sample is pushed out to full radius
      set_config(15'd1, 15'd0);
      send_sample(16'sd1, 16'sd0);
      send_sample(-16'sd1, 16'sd0);
      send_sample(16'sh8000, 16'sh7fff);
      // writes to undefined indexes are ignored
      drain_results();
      write_reg(2'd2, 15'h7fff);
      write_reg(2'd3, 15'h0000);
      send_sample(16'sd7, 16'sd7);
      set_config(15'd32767, 15'd32766);
      send_sample(16'sh7fff, 16'sd0);
      send_sample(16'sh8000, 16'sd0);
   endtask

   task automatic test_random_samples(int count);
      repeat (count) begin
         pace_sender();
         send_sample(pick_axis(), pick_axis());
      end
   endtask

   task automatic test_config_sweep();
      int fs;
      set_config(15'd32767, 15'd0);
      test_random_samples(150);
      set_config(15'd32767, 15'd32766);
      test_random_samples(100);
      set_config(15'd1, 15'd0);
      test_random_samples(100);
      set_config(15'd32767, 15'd7849);
      test_random_samples(150);
      repeat (6) begin
         fs = $urandom_range(1, 32767);
         set_config(15'(fs), 15'($urandom_range(0, fs)));
         test_random_samples(120);
      end
      // finally a dead radius above full scale
      set_config(15'($urandom_range(0, 16000)), 15'($urandom_range(16001, 32767)));
      test_random_samples(60);
   endtask

   initial begin
      full_scale_q  = rsd_pkg::FULL_SCALE_RST;
      dead_radius_q = rsd_pkg::DEAD_RADIUS_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_random_samples(80);
      test_config_edges();
      test_config_sweep();

      drain_results();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
hdl/rsd_pkg.sv
hdl/rsd_sqrt.sv
hdl/rsd_div.sv
hdl/radial_stick_deadzone.sv
hdl/rsd_checker.sv
verif/radial_stick_deadzone_tb.sv
